// File: hw/rtl/ada_pkg.sv
package ada_pkg;

  localparam int ValW  = 32;
  localparam int AccW  = 48;
  localparam int CfgW  = 32;
  localparam int AddrW = 4;
  localparam int RadW  = 64;   // radicand: {0, x(49), 14 zeros}
  localparam int RootW = 32;
  localparam int NumW  = 64;   // dividend, top bit always zero
  localparam int DivW  = 34;   // divisor: 2*root or 1

  localparam int SqrtStepsDef = 4;
  localparam int DivStepsDef  = 4;

  localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

  localparam logic [1:0] RegLr    = 2'd0;
  localparam logic [1:0] RegDecay = 2'd1;
  localparam logic [1:0] RegEps   = 2'd2;

  localparam logic [CfgW-1:0] LrReset    = 32'd65536;
  localparam logic [CfgW-1:0] DecayReset = 32'd0;
  localparam logic [CfgW-1:0] EpsReset   = 32'd1;

  typedef struct packed {
    logic [CfgW-1:0] lr;
    logic [CfgW-1:0] decay;
    logic [CfgW-1:0] eps;
  } cfg_t;

  // per-element data that rides along with the root and divide units
  typedef struct packed {
    logic [ValW-1:0] val;
    logic            gneg;
    logic            sat;
    logic [AccW-1:0] nacc;
  } side_t;

  typedef struct packed {
    side_t           side;
    logic [NumW-2:0] num;
  } sq_tag_t;

endpackage

// File: hw/rtl/ada_in_if.sv
interface ada_in_if;
  logic        valid;
  logic        ready;
  logic        is_bias;
  logic signed [31:0] param_value;
  logic signed [31:0] gradient;
  logic [47:0] accumulator;

  modport source (output valid, output is_bias, output param_value, output gradient,
                  output accumulator, input ready);
  modport sink (input valid, input is_bias, input param_value, input gradient,
                input accumulator, output ready);
endinterface

// File: hw/rtl/ada_out_if.sv
interface ada_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] new_value;
  logic [47:0] new_accumulator;
  logic        saturated;

  modport source (output valid, output new_value, output new_accumulator,
                  output saturated, input ready);
  modport sink (input valid, input new_value, input new_accumulator,
                input saturated, output ready);
endinterface

// File: hw/rtl/ada_regs.sv
module ada_regs import ada_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [CfgW-1:0]  pwdata,
  output logic [CfgW-1:0]  prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q;
  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lr    <= LrReset;
      cfg_q.decay <= DecayReset;
      cfg_q.eps   <= EpsReset;
    end else if (wr) begin
      unique case (idx)
        RegLr:    cfg_q.lr    <= pwdata;
        RegDecay: cfg_q.decay <= pwdata;
        RegEps:   cfg_q.eps   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegLr:    prdata = cfg_q.lr;
      RegDecay: prdata = cfg_q.decay;
      RegEps:   prdata = cfg_q.eps;
      default:  prdata = '0;
    endcase
  end

  // write to an unmapped slot leaves every register alone
  a_unmapped_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && !(idx == RegLr || idx == RegDecay || idx == RegEps)) |=> $stable(cfg_q))
    else $error("unmapped write changed a register");

endmodule

// File: hw/rtl/ada_sqrt.sv
// Pipelined digit-by-digit integer square root, Steps result bits per stage.
module ada_sqrt import ada_pkg::*; #(
  parameter int Steps = SqrtStepsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [RadW-1:0]  rad_i,
  input  sq_tag_t          tag_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [RootW-1:0] root_o,
  output sq_tag_t          tag_o
);

  localparam int N = RootW / Steps;

  logic             v_q    [N];
  logic             en     [N];
  logic [RadW-1:0]  rad_q  [N];
  logic [RootW+2:0] rem_q  [N];
  logic [RootW-1:0] root_q [N];
  sq_tag_t          tag_q  [N];

  always_comb begin
    en[N-1] = !v_q[N-1] || ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic             vin;
    logic [RadW-1:0]  r_in, r;
    logic [RootW+2:0] m_in, m, tr;
    logic [RootW-1:0] q_in, q;
    sq_tag_t          t_in;

    if (k == 0) begin : g_first
      assign vin  = valid_i;
      assign r_in = rad_i;
      assign m_in = '0;
      assign q_in = '0;
      assign t_in = tag_i;
    end else begin : g_next
      assign vin  = v_q[k-1];
      assign r_in = rad_q[k-1];
      assign m_in = rem_q[k-1];
      assign q_in = root_q[k-1];
      assign t_in = tag_q[k-1];
    end

    always_comb begin
      r  = r_in;
      m  = m_in;
      q  = q_in;
      tr = '0;
      for (int j = 0; j < Steps; j++) begin
        m  = {m[RootW:0], r[RadW-1 -: 2]};
        tr = {1'b0, q, 2'b01};
        if (m >= tr) begin
          m = m - tr;
          q = {q[RootW-2:0], 1'b1};
        end else begin
          q = {q[RootW-2:0], 1'b0};
        end
        r = {r[RadW-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rad_q[k]  <= r;
        rem_q[k]  <= m;
        root_q[k] <= q;
        tag_q[k]  <= t_in;
      end
    end

    // remainder never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      v_q[k] |-> (rem_q[k] <= {2'b00, root_q[k], 1'b0}))
      else $error("sqrt remainder out of bound");
  end

  assign valid_o = v_q[N-1];
  assign root_o  = root_q[N-1];
  assign tag_o   = tag_q[N-1];

endmodule

// File: hw/rtl/ada_div.sv
// Pipelined restoring divider, Steps quotient bits per stage.
module ada_div import ada_pkg::*; #(
  parameter int Steps = DivStepsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [NumW-1:0] num_i,
  input  logic [DivW-1:0] den_i,
  input  side_t           side_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [NumW-1:0] quo_o,
  output side_t           side_o
);

  localparam int N = NumW / Steps;

  logic            v_q   [N];
  logic            en    [N];
  logic [NumW-1:0] num_q [N];
  logic [DivW-1:0] rem_q [N];
  logic [NumW-1:0] quo_q [N];
  logic [DivW-1:0] den_q [N];
  side_t           side_q[N];

  always_comb begin
    en[N-1] = !v_q[N-1] || ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic            vin;
    logic [NumW-1:0] n_in, n, q_in, q;
    logic [DivW-1:0] rm_in, d_in;
    logic [DivW:0]   m;
    side_t           s_in;

    if (k == 0) begin : g_first
      assign vin   = valid_i;
      assign n_in  = num_i;
      assign rm_in = '0;
      assign q_in  = '0;
      assign d_in  = den_i;
      assign s_in  = side_i;
    end else begin : g_next
      assign vin   = v_q[k-1];
      assign n_in  = num_q[k-1];
      assign rm_in = rem_q[k-1];
      assign q_in  = quo_q[k-1];
      assign d_in  = den_q[k-1];
      assign s_in  = side_q[k-1];
    end

    always_comb begin
      n = n_in;
      q = q_in;
      m = {1'b0, rm_in};
      for (int j = 0; j < Steps; j++) begin
        m = {m[DivW-1:0], n[NumW-1]};
        if (m >= {1'b0, d_in}) begin
          m = m - {1'b0, d_in};
          q = {q[NumW-2:0], 1'b1};
        end else begin
          q = {q[NumW-2:0], 1'b0};
        end
        n = {n[NumW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        num_q[k]  <= n;
        rem_q[k]  <= m[DivW-1:0];
        quo_q[k]  <= q;
        den_q[k]  <= d_in;
        side_q[k] <= s_in;
      end
    end

    a_rem_lt_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
      v_q[k] |-> (rem_q[k] < den_q[k]))
      else $error("divider remainder not below divisor");
  end

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> (den_q[0] != '0))
    else $error("divider fed a zero divisor");

  assign valid_o = v_q[N-1];
  assign quo_o   = quo_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

// File: hw/rtl/adagrad_element_update_top.sv
// Adagrad update for one parameter element per beat.
//
// Input channel (in_i): is_bias, param_value (Q16.16), gradient (Q16.16),
// accumulator (unsigned Q32.16). Output channel (out_o): new_value,
// new_accumulator and a saturated flag, one result beat per input beat,
// in order. Both channels use valid/ready; a beat moves when both are high.
// APB port: learning_rate at 0x0, decay at 0x4, epsilon at 0x8; write
// only while the pipeline is empty.
//
// The path from input beat to output valid runs through five front stages
// (decay multiply, sum, square, accumulate, add epsilon), the root pipeline,
// the divide pipeline, and the output register. Throughput: one beat per
// cycle while the receiver does not stall.
//
// Reset clears all valid bits and loads the register reset values.
// When the receiver stalls, the output register holds its beat; each stage
// keeps moving while the stage after it has room, so bubbles are squeezed
// out and the input keeps taking beats until the pipeline is full.
module adagrad_element_update_top import ada_pkg::*; #(
  parameter int SqrtSteps = SqrtStepsDef,
  parameter int DivSteps  = DivStepsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ada_in_if.sink           in_i,
  ada_out_if.source        out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [CfgW-1:0]  pwdata,
  output logic [CfgW-1:0]  prdata,
  output logic             pready
);

  cfg_t cfg;

  ada_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  // ---------------- stage enables (ready chain) ----------------
  logic en1, en2, en3, en4, en5, sq_ready;
  logic f1_v_q, f2_v_q, f3_v_q, f4_v_q, f5_v_q;

  assign en5 = !f5_v_q || sq_ready;
  assign en4 = !f4_v_q || en5;
  assign en3 = !f3_v_q || en4;
  assign en2 = !f2_v_q || en3;
  assign en1 = !f1_v_q || en2;
  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
      f4_v_q <= 1'b0;
      f5_v_q <= 1'b0;
    end else begin
      if (en1) f1_v_q <= in_i.valid;
      if (en2) f2_v_q <= f1_v_q;
      if (en3) f3_v_q <= f2_v_q;
      if (en4) f4_v_q <= f3_v_q;
      if (en5) f5_v_q <= f4_v_q;
    end
  end

  // ---------------- F1: magnitudes and the two products ----------------
  logic [31:0] vmag, gmag;
  logic        f1_bias_q;
  logic [31:0] f1_val_q, f1_grad_q;
  logic [47:0] f1_acc_q;
  logic [63:0] f1_dprod_q, f1_lprod_q;

  assign vmag = in_i.param_value[31] ? (~in_i.param_value + 32'd1) : in_i.param_value;
  assign gmag = in_i.gradient[31] ? (~in_i.gradient + 32'd1) : in_i.gradient;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      f1_bias_q  <= in_i.is_bias;
      f1_val_q   <= in_i.param_value;
      f1_grad_q  <= in_i.gradient;
      f1_acc_q   <= in_i.accumulator;
      f1_dprod_q <= 64'(cfg.decay) * 64'(vmag);
      f1_lprod_q <= 64'(cfg.lr) * 64'(gmag);
    end
  end

  // ---------------- F2: t = gradient +/- decay term, |t| ----------------
  logic [47:0] term;
  logic [49:0] t_sum, t_mag;
  logic        f2_big_q, f2_gneg_q;
  logic [31:0] f2_tmag_q, f2_val_q;
  logic [47:0] f2_acc_q;
  logic [62:0] f2_lprod_q;

  always_comb begin
    term  = f1_bias_q ? 48'd0 : f1_dprod_q[63:16];
    if (f1_val_q[31]) begin
      t_sum = {{18{f1_grad_q[31]}}, f1_grad_q} - {2'b00, term};
    end else begin
      t_sum = {{18{f1_grad_q[31]}}, f1_grad_q} + {2'b00, term};
    end
    t_mag = t_sum[49] ? (~t_sum + 50'd1) : t_sum;
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      f2_big_q   <= |t_mag[49:32];
      f2_tmag_q  <= t_mag[31:0];
      f2_gneg_q  <= f1_grad_q[31];
      f2_val_q   <= f1_val_q;
      f2_acc_q   <= f1_acc_q;
      f2_lprod_q <= f1_lprod_q[62:0];
    end
  end

  // ---------------- F3: square ----------------
  logic [63:0] f3_sq_q;
  logic        f3_big_q, f3_gneg_q;
  logic [31:0] f3_val_q;
  logic [47:0] f3_acc_q;
  logic [62:0] f3_lprod_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      f3_sq_q    <= 64'(f2_tmag_q) * 64'(f2_tmag_q);
      f3_big_q   <= f2_big_q;
      f3_gneg_q  <= f2_gneg_q;
      f3_val_q   <= f2_val_q;
      f3_acc_q   <= f2_acc_q;
      f3_lprod_q <= f2_lprod_q;
    end
  end

  // ---------------- F4: accumulate with clamp ----------------
  logic [48:0] acc_sum;
  side_t       f4_side_q;
  logic [62:0] f4_lprod_q;

  assign acc_sum = {1'b0, f3_acc_q} + {1'b0, f3_sq_q[63:16]};

  always_ff @(posedge clk_i) begin
    if (en4) begin
      f4_side_q.val  <= f3_val_q;
      f4_side_q.gneg <= f3_gneg_q;
      f4_side_q.sat  <= f3_big_q || acc_sum[48];
      f4_side_q.nacc <= (f3_big_q || acc_sum[48]) ? AccMax : acc_sum[47:0];
      f4_lprod_q     <= f3_lprod_q;
    end
  end

  // ---------------- F5: x = new accumulator + epsilon ----------------
  logic [48:0] f5_x_q;
  sq_tag_t     f5_tag_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      f5_x_q        <= {1'b0, f4_side_q.nacc} + {17'd0, cfg.eps};
      f5_tag_q.side <= f4_side_q;
      f5_tag_q.num  <= f4_lprod_q;
    end
  end

  // ---------------- root: s = isqrt(x * 2^14) ----------------
  logic             sq_v, div_ready;
  logic [RootW-1:0] root;
  sq_tag_t          sq_tag;

  ada_sqrt #(.Steps(SqrtSteps)) u_sqrt (
    .clk_i, .rst_ni,
    .valid_i (f5_v_q),
    .ready_o (sq_ready),
    .rad_i   ({1'b0, f5_x_q, 14'd0}),
    .tag_i   (f5_tag_q),
    .valid_o (sq_v),
    .ready_i (div_ready),
    .root_o  (root),
    .tag_o   (sq_tag)
  );

  // ---------------- step: lr*|g| / (2s), divisor 1 when s is zero ----------------
  logic [DivW-1:0] den;
  logic            dv_v, out_en;
  logic [NumW-1:0] quo;
  side_t           dv_side;

  assign den = (root == '0) ? DivW'(1) : {1'b0, root, 1'b0};

  ada_div #(.Steps(DivSteps)) u_div (
    .clk_i, .rst_ni,
    .valid_i (sq_v),
    .ready_o (div_ready),
    .num_i   ({1'b0, sq_tag.num}),
    .den_i   (den),
    .side_i  (sq_tag.side),
    .valid_o (dv_v),
    .ready_i (out_en),
    .quo_o   (quo),
    .side_o  (dv_side)
  );

  // ---------------- output: apply step, clamp to Q16.16 ----------------
  logic        q_big, clamp;
  logic [34:0] val_x, nv;
  logic [31:0] nv_sat;
  logic        out_v_q, out_sat_q;
  logic [31:0] out_val_q;
  logic [47:0] out_acc_q;

  always_comb begin
    q_big = |quo[NumW-1:33];
    val_x = {{3{dv_side.val[31]}}, dv_side.val};
    nv    = dv_side.gneg ? (val_x + {2'b00, quo[32:0]}) : (val_x - {2'b00, quo[32:0]});
    if (q_big) begin
      clamp  = 1'b1;
      nv_sat = dv_side.gneg ? 32'h7FFF_FFFF : 32'h8000_0000;
    end else if (!(nv[34:31] == 4'b0000 || nv[34:31] == 4'b1111)) begin
      clamp  = 1'b1;
      nv_sat = nv[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      clamp  = 1'b0;
      nv_sat = nv[31:0];
    end
  end

  assign out_en = !out_v_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_val_q <= nv_sat;
      out_acc_q <= dv_side.nacc;
      out_sat_q <= dv_side.sat || clamp;
    end
  end

  assign out_o.valid           = out_v_q;
  assign out_o.new_value       = out_val_q;
  assign out_o.new_accumulator = out_acc_q;
  assign out_o.saturated       = out_sat_q;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

// Adagrad element update: random and directed elements are streamed into the
// input channel; an in-house predictor computes each expected result, and the
// output channel is compared beat by beat against a FIFO of predictions.
module testbench;
  import ada_pkg::*;

  typedef struct packed {
    logic            is_bias;
    logic [ValW-1:0] param_value;
    logic [ValW-1:0] gradient;
    logic [AccW-1:0] accumulator;
  } elem_t;

  typedef struct packed {
    logic [ValW-1:0] new_value;
    logic [AccW-1:0] new_accumulator;
    logic            saturated;
  } upd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [CfgW-1:0] pwdata = '0;
  logic [CfgW-1:0] prdata;
  logic pready;

  ada_in_if  elem_ch ();
  ada_out_if upd_ch ();

  adagrad_element_update_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(elem_ch.sink), .out_o(upd_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the registers
  logic [CfgW-1:0] lr_q = LrReset, decay_q = DecayReset, eps_q = EpsReset;

  elem_t pending_elems[$];
  upd_t  expected_upds[$];
  int    mismatches = 0;
  int    beats_in = 0, beats_out = 0, sat_seen = 0;
  int    send_idle_pct = 0, recv_stall_pct = 0;
  logic  in_taken_q = 1'b0;

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] root, bit_v;
    root = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= root + bit_v) begin
        x -= root + bit_v;
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    return root;
  endfunction

  function automatic upd_t adagrad_update(elem_t e);
    upd_t r;
    longint val, grad, t, nv;
    logic [63:0] vmag, term, tmag, incr, nacc, x, s, divisor, gmag, dmag;
    logic sat;
    val = longint'(signed'(e.param_value));
    grad = longint'(signed'(e.gradient));
    sat = 1'b0;
    t = grad;
    if (!e.is_bias) begin
      vmag = val < 0 ? -val : val;
      term = (64'(decay_q) * vmag) >> 16;
      t = val < 0 ? t - longint'(term) : t + longint'(term);
    end
    tmag = t < 0 ? -t : t;
    if (tmag >= 64'h1_0000_0000) begin
      nacc = 64'(AccMax);
      sat = 1'b1;
    end else begin
      incr = (tmag * tmag) >> 16;
      if (incr > 64'(AccMax) - 64'(e.accumulator)) begin
        nacc = 64'(AccMax);
        sat = 1'b1;
      end else begin
        nacc = 64'(e.accumulator) + incr;
      end
    end
    x = nacc + 64'(eps_q);
    s = int_sqrt(x << 14);
    divisor = (s == 0) ? 64'd1 : 2 * s;
    gmag = grad < 0 ? -grad : grad;
    dmag = (64'(lr_q) * gmag) / divisor;
    nv = grad < 0 ? val + longint'(dmag) : val - longint'(dmag);
    if (nv > 64'sd2147483647) begin
      nv = 64'sd2147483647;
      sat = 1'b1;
    end else if (nv < -64'sd2147483648) begin
      nv = -64'sd2147483648;
      sat = 1'b1;
    end
    r.new_value = nv[31:0];
    r.new_accumulator = nacc[AccW-1:0];
    r.saturated = sat;
    return r;
  endfunction

  // input handshake as seen at the rising edge
  always @(posedge clk_i) begin
    in_taken_q <= rst_ni && elem_ch.valid && elem_ch.ready;
  end

  // driver: falling edge, fed from pending_elems
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      elem_ch.valid <= 1'b0;
    end else begin
      if (!elem_ch.valid || in_taken_q) begin
        if (pending_elems.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          elem_t e;
          e = pending_elems.pop_front();
          expected_upds.push_back(adagrad_update(e));
          elem_ch.valid <= 1'b1;
          elem_ch.is_bias <= e.is_bias;
          elem_ch.param_value <= e.param_value;
          elem_ch.gradient <= e.gradient;
          elem_ch.accumulator <= e.accumulator;
          beats_in++;
        end else begin
          elem_ch.valid <= 1'b0;
        end
      end
      upd_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: rising edge
  always @(posedge clk_i) begin
    if (rst_ni && upd_ch.valid && upd_ch.ready) begin
      upd_t exp_u;
      beats_out++;
      if (expected_upds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        exp_u = expected_upds.pop_front();
        if (upd_ch.saturated) sat_seen++;
        if (exp_u.new_value !== upd_ch.new_value ||
            exp_u.new_accumulator !== upd_ch.new_accumulator ||
            exp_u.saturated !== upd_ch.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch beat %0d: exp val %h acc %h sat %b, got val %h acc %h sat %b",
                     beats_out, exp_u.new_value, exp_u.new_accumulator, exp_u.saturated,
                     upd_ch.new_value, upd_ch.new_accumulator, upd_ch.saturated);
        end
      end
    end
  end

  initial begin
    elem_ch.valid = 1'b0;
    elem_ch.is_bias = 1'b0;
    elem_ch.param_value = '0;
    elem_ch.gradient = '0;
    elem_ch.accumulator = '0;
    upd_ch.ready = 1'b0;
  end

  // APB write: setup then access; pready is always high
  task automatic reg_write(logic [1:0] idx, logic [CfgW-1:0] data);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= AddrW'({idx, 2'b00}); pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      RegLr:    lr_q = data;
      RegDecay: decay_q = data;
      RegEps:   eps_q = data;
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending_elems.size() != 0 || expected_upds.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic elem_t rand_elem();
    elem_t e;
    e.is_bias = 1'($urandom_range(1));
    // mix of small magnitudes (realistic) and full-range values
    case ($urandom_range(3))
      0: begin
        e.param_value = $urandom;
        e.gradient = $urandom;
        e.accumulator = 48'({$urandom, $urandom});
      end
      default: begin
        e.param_value = 32'($signed($urandom_range(262144)) - 131072);
        e.gradient = 32'($signed($urandom_range(131072)) - 65536);
        e.accumulator = 48'($urandom_range(32'h00ff_ffff));
      end
    endcase
    return e;
  endfunction

  task automatic push(logic b, logic [31:0] v, logic [31:0] g, logic [47:0] a);
    elem_t e;
    e.is_bias = b; e.param_value = v; e.gradient = g; e.accumulator = a;
    pending_elems.push_back(e);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, bias and weight forms, saturation on both outputs
    push(1'b0, 32'h0, 32'h0, 48'h0);
    push(1'b1, 32'h7fff_ffff, 32'h8000_0000, 48'h0);
    push(1'b0, 32'h8000_0000, 32'h7fff_ffff, AccMax);
    push(1'b1, 32'h8000_0000, 32'h8000_0000, AccMax);
    push(1'b0, 32'h7fff_ffff, 32'hffff_ffff, 48'h1);
    push(1'b1, 32'h0001_0000, 32'h0001_0000, 48'h0);
    push(1'b0, 32'hffff_0000, 32'hfffe_0000, 48'h10000);
    drain();

    // zero under the root, huge rate, strong decay
    reg_write(RegEps, 32'd0);
    reg_write(RegLr, 32'hffff_ffff);
    reg_write(RegDecay, 32'hffff_ffff);
    push(1'b1, 32'h0, 32'h0, 48'h0);
    push(1'b1, 32'h1234_5678, 32'h0, 48'h0);
    push(1'b1, 32'h0, 32'h0000_0001, 48'h0);
    push(1'b0, 32'h7fff_ffff, 32'h8000_0000, 48'h0);
    push(1'b0, 32'h8000_0000, 32'h7fff_ffff, 48'h0);
    push(1'b0, 32'h0000_0100, 32'hffff_ff00, 48'h0);
    drain();

    // zero learning rate leaves the value unchanged
    reg_write(RegLr, 32'd0);
    reg_write(RegEps, 32'hffff_ffff);
    push(1'b0, 32'h1357_9bdf, 32'h7fff_ffff, 48'h5);
    push(1'b1, 32'h8000_0000, 32'h8000_0000, AccMax);
    drain();

    // random phases, each with its own register setting and one of four idle/stall patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 55; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 55; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      reg_write(RegLr, (ph == 0) ? 32'd1 : (ph == 7) ? 32'hffff_ffff : $urandom_range(32'h0004_0000, 1));
      reg_write(RegDecay, (ph == 1) ? 32'd0 : (ph == 6) ? 32'hffff_ffff : $urandom_range(32'h0000_2000));
      reg_write(RegEps, (ph == 2) ? 32'd1 : (ph == 5) ? 32'hffff_ffff : $urandom_range(32'h0001_0000, 1));
      for (int k = 0; k < 62; k++) pending_elems.push_back(rand_elem());
      drain();
    end

    $display("Covered %0d element beats, %0d results (%0d saturated), over 11 register settings",
             beats_in, beats_out, sat_seen);
    $display("and four idle/stall patterns; %0d mismatches", mismatches);
    if (mismatches == 0 && expected_upds.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
